// ===== rtl/aging_priority_scheduler_defines.svh =====
// Assertion macros for the aging priority scheduler.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef AGING_PRIORITY_SCHEDULER_DEFINES_SVH
`define AGING_PRIORITY_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define APS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// antecedent implies consequent in the next cycle
`define APS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define APS_ASSERT_NOW(label, ante, cons, msg)
`define APS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/aps_pkg.sv =====
// Shared types, constants and helpers for the aging priority scheduler.
// No dependencies; used by aps_ctrl, aps_dp and the top level.
package aps_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int ID_W     = 8;
   localparam int TIME_W   = 16;
   localparam int CT_W     = 32;
   localparam int PRIO_W   = 16;
   localparam int Q_W      = 8;
   localparam int GAIN_W   = 4;
   localparam int STATUS_W = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_GAIN = 2'd2;

   localparam logic [Q_W-1:0]    QUANTUM_RST   = 8'd1;
   localparam logic [GAIN_W-1:0] RUN_GAIN_RST  = 4'd1;
   localparam logic [GAIN_W-1:0] WAIT_GAIN_RST = 4'd2;

   // request kinds
   localparam logic KIND_ADMIT = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ADMITTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RAN      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd3;

   localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

   typedef struct packed {
      logic              capture;   // latch request fields, clear scan state
      logic              admit;     // place the latched process in a free slot
      logic              scan;      // examine one slot
      logic [SLOT_W-1:0] scan_idx;
      logic              run;       // run the pick, or jump the clock if none
      logic              age;       // priority aging, done bit, turnaround
      logic              finish;    // waiting time, assemble result
      logic              load_rsp;  // move pending result to the output
   } cmd_type;

   typedef struct packed {
      logic found;     // scan found an eligible process
      logic rsp_free;  // output register can take a result this cycle
   } sts_type;

   function automatic logic [PRIO_W-1:0] sat_add(input logic [PRIO_W-1:0] p,
                                                 input logic [GAIN_W-1:0] g);
      logic [PRIO_W:0] s;
      s = {1'b0, p} + (PRIO_W+1)'(g);
      return s[PRIO_W] ? PRIO_MAX : s[PRIO_W-1:0];
   endfunction

endpackage

// ===== rtl/aging_priority_scheduler.sv =====
// Top level of the aging priority scheduler: sequencer plus datapath.
// Depends on aps_pkg, aps_ctrl, aps_dp and aging_priority_scheduler_defines.svh.
//
//   channel  handshake           payload
//   req      req_valid/req_stall kind, process_id, arrival_time, burst
//   rsp      rsp_valid/rsp_stall status, ran_id, run_amount, finished,
//                                turnaround, waiting
//   csr      csr_wr_en           csr_index, csr_wdata (no read-back)
//
// Admit request: the table write follows accept, then the result is registered in the output.
// Step request: the slot scan examines one slot per cycle, then run, aging,
// result assembly and the output load follow in that order.
// An idle step skips aging and assembly.
// Reset (synchronous) clears the slot used/done bits and the clock, and sets config to its reset values.
// req_stall is high from accept until the result moves to the output
// register; a stalled result holds there while the next request is taken.

`include "aging_priority_scheduler_defines.svh"

module aging_priority_scheduler (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_kind,
   input  logic [aps_pkg::ID_W-1:0]                req_process_id,
   input  logic [aps_pkg::TIME_W-1:0]              req_arrival_time,
   input  logic [aps_pkg::TIME_W-1:0]              req_burst,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [aps_pkg::STATUS_W-1:0]            rsp_status,
   output logic [aps_pkg::ID_W-1:0]                rsp_ran_id,
   output logic [aps_pkg::Q_W-1:0]                 rsp_run_amount,
   output logic                                    rsp_finished,
   output logic [aps_pkg::CT_W-1:0]                rsp_turnaround,
   output logic [aps_pkg::CT_W-1:0]                rsp_waiting,
   // config write port
   input  logic                                    csr_wr_en,
   input  logic [aps_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [aps_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   aps_pkg::cmd_type cmd;
   aps_pkg::sts_type sts;

   // sequencer: one state per phase, slot counter for the scan
   aps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot table, selection registers, run/aging arithmetic, output register
   aps_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_process_id   (req_process_id),
      .req_arrival_time (req_arrival_time),
      .req_burst        (req_burst),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_ran_id       (rsp_ran_id),
      .rsp_run_amount   (rsp_run_amount),
      .rsp_finished     (rsp_finished),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting)
   );

   // one request in flight: the sequencer must leave idle right after accept
   `APS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted request did not make the block busy")
   // only a step that ran a process carries id and run amount
   `APS_ASSERT_NOW(a_fields_only_when_ran, rsp_valid && (rsp_status != aps_pkg::ST_RAN), (rsp_ran_id == '0) && (rsp_run_amount == '0) && !rsp_finished, "non-run result has run fields set")
   // timing figures appear only on completion
   `APS_ASSERT_NOW(a_times_only_when_done, rsp_valid && !rsp_finished, (rsp_turnaround == '0) && (rsp_waiting == '0), "times reported without completion")

endmodule

// ===== rtl/aps_ctrl.sv =====
// Sequencer for the aging priority scheduler.
// Depends on aps_pkg; drives aps_dp through cmd_type, reads sts_type.
module aps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_kind,
   output logic              req_stall,
   input  aps_pkg::sts_type  sts,
   output aps_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADMIT  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_RUN    = 3'd3;
   localparam logic [2:0] S_AGE    = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [aps_pkg::SLOT_W-1:0]  idx_ff, idx_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.scan_idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               idx_in      = '0;
               state_in    = (req_kind == aps_pkg::KIND_STEP) ? S_SCAN : S_ADMIT;
            end
         end
         S_ADMIT: begin
            cmd.admit = 1'b1;
            state_in  = S_RESULT;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            idx_in   = idx_ff + aps_pkg::SLOT_W'(1);
            if (idx_ff == aps_pkg::SLOT_W'(aps_pkg::SLOTS - 1)) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.run  = 1'b1;
            state_in = sts.found ? S_AGE : S_RESULT;
         end
         S_AGE: begin
            cmd.age  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/aps_dp.sv =====
// Datapath of the aging priority scheduler: slot table, scan, run, aging,
// config registers and output register. Depends on aps_pkg.
module aps_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  aps_pkg::cmd_type                  cmd,
   output aps_pkg::sts_type                  sts,
   input  logic [aps_pkg::ID_W-1:0]          req_process_id,
   input  logic [aps_pkg::TIME_W-1:0]        req_arrival_time,
   input  logic [aps_pkg::TIME_W-1:0]        req_burst,
   input  logic                              csr_wr_en,
   input  logic [aps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [aps_pkg::STATUS_W-1:0]      rsp_status,
   output logic [aps_pkg::ID_W-1:0]          rsp_ran_id,
   output logic [aps_pkg::Q_W-1:0]           rsp_run_amount,
   output logic                              rsp_finished,
   output logic [aps_pkg::CT_W-1:0]          rsp_turnaround,
   output logic [aps_pkg::CT_W-1:0]          rsp_waiting
);

   localparam int N   = aps_pkg::SLOTS;
   localparam int SW  = aps_pkg::SLOT_W;
   localparam int TW  = aps_pkg::TIME_W;
   localparam int CW  = aps_pkg::CT_W;
   localparam int PW  = aps_pkg::PRIO_W;
   localparam int QW  = aps_pkg::Q_W;
   localparam int GW  = aps_pkg::GAIN_W;
   localparam int IW  = aps_pkg::ID_W;

   // config
   logic [QW-1:0] quantum_ff;
   logic [GW-1:0] run_gain_ff;
   logic [GW-1:0] wait_gain_ff;

   // latched request
   logic [IW-1:0] new_id_ff;
   logic [TW-1:0] new_arr_ff;
   logic [TW-1:0] new_burst_ff;

   // slot table
   logic [N-1:0]  used_ff;
   logic [N-1:0]  done_ff;
   logic [IW-1:0] slot_id_ff    [N];
   logic [TW-1:0] slot_arr_ff   [N];
   logic [TW-1:0] slot_burst_ff [N];
   logic [TW-1:0] slot_rem_ff   [N];
   logic [PW-1:0] slot_prio_ff  [N];
   logic [CW-1:0] slot_last_ff  [N];
   logic [PW-1:0] prio_age      [N];

   logic [CW-1:0] ct_ff;

   // scan state
   logic          best_valid_ff;
   logic [SW-1:0] best_idx_ff;
   logic [PW-1:0] best_prio_ff;
   logic [CW-1:0] best_last_ff;
   logic [TW-1:0] best_arr_ff;
   logic          next_any_ff;
   logic [TW-1:0] next_arr_ff;

   // run state
   logic [QW-1:0] run_ff;
   logic          fin_ff;
   logic [CW-1:0] ta_ff;

   // pending result
   logic [aps_pkg::STATUS_W-1:0] p_status_ff;
   logic [IW-1:0]                p_id_ff;
   logic [QW-1:0]                p_run_ff;
   logic                         p_fin_ff;
   logic [CW-1:0]                p_ta_ff;
   logic [CW-1:0]                p_wait_ff;

   logic          rsp_valid_ff;

   // free slot search
   logic [N-1:0]  free_vec;
   logic          free_found;
   logic [SW-1:0] free_idx;

   // scan compare
   logic          sc_undone, sc_elig, sc_better;
   logic [SW-1:0] si;

   // run arithmetic
   logic [TW-1:0] rem_sel;
   logic [QW-1:0] run_amt;
   logic [TW-1:0] rem_next;
   logic [CW-1:0] ct_run;

   assign free_vec = ~used_ff | done_ff;

   always_comb begin
      free_found = |free_vec;
      free_idx   = '0;
      for (int s = N - 1; s >= 0; s--) begin
         if (free_vec[s]) free_idx = SW'(s);
      end
   end

   assign si        = cmd.scan_idx;
   assign sc_undone = used_ff[si] & ~done_ff[si];
   assign sc_elig   = sc_undone & (CW'(slot_arr_ff[si]) <= ct_ff);
   assign sc_better = !best_valid_ff
                   || (slot_prio_ff[si] > best_prio_ff)
                   || ((slot_prio_ff[si] == best_prio_ff)
                       && (slot_last_ff[si] < best_last_ff));

   assign rem_sel  = slot_rem_ff[best_idx_ff];
   assign run_amt  = (rem_sel < TW'(quantum_ff)) ? rem_sel[QW-1:0] : quantum_ff;
   assign rem_next = rem_sel - TW'(run_amt);
   assign ct_run   = ct_ff + CW'(run_amt);

   // aging, with the clock already advanced
   always_comb begin
      for (int s = 0; s < N; s++) begin
         if (best_idx_ff == SW'(s))
            prio_age[s] = aps_pkg::sat_add(slot_prio_ff[s], run_gain_ff);
         else if (used_ff[s] && !done_ff[s] && (CW'(slot_arr_ff[s]) < ct_ff))
            prio_age[s] = aps_pkg::sat_add(slot_prio_ff[s], wait_gain_ff);
         else
            prio_age[s] = slot_prio_ff[s];
      end
   end

   assign sts.found    = best_valid_ff;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff    <= aps_pkg::QUANTUM_RST;
         run_gain_ff   <= aps_pkg::RUN_GAIN_RST;
         wait_gain_ff  <= aps_pkg::WAIT_GAIN_RST;
         used_ff       <= '0;
         done_ff       <= '0;
         ct_ff         <= '0;
         best_valid_ff <= 1'b0;
         next_any_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               aps_pkg::CSR_QUANTUM:   quantum_ff   <= csr_wdata[QW-1:0];
               aps_pkg::CSR_RUN_GAIN:  run_gain_ff  <= csr_wdata[GW-1:0];
               aps_pkg::CSR_WAIT_GAIN: wait_gain_ff <= csr_wdata[GW-1:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            best_valid_ff <= 1'b0;
            next_any_ff   <= 1'b0;
         end
         if (cmd.scan) begin
            if (sc_elig && sc_better) best_valid_ff <= 1'b1;
            if (sc_undone) next_any_ff <= 1'b1;
         end
         if (cmd.admit && free_found) begin
            used_ff[free_idx] <= 1'b1;
            done_ff[free_idx] <= 1'b0;
         end
         if (cmd.run) begin
            if (best_valid_ff)
               ct_ff <= ct_run;
            else if (next_any_ff && (CW'(next_arr_ff) > ct_ff))
               ct_ff <= CW'(next_arr_ff);
         end
         if (cmd.age && fin_ff) done_ff[best_idx_ff] <= 1'b1;
         if (cmd.load_rsp)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_id_ff    <= req_process_id;
         new_arr_ff   <= req_arrival_time;
         new_burst_ff <= req_burst;
      end

      if (cmd.scan) begin
         if (sc_elig && sc_better) begin
            best_idx_ff  <= si;
            best_prio_ff <= slot_prio_ff[si];
            best_last_ff <= slot_last_ff[si];
            best_arr_ff  <= slot_arr_ff[si];
         end
         if (sc_undone && (!next_any_ff || (slot_arr_ff[si] < next_arr_ff)))
            next_arr_ff <= slot_arr_ff[si];
      end

      for (int s = 0; s < N; s++) begin
         if (cmd.admit && free_found && (free_idx == SW'(s))) begin
            slot_id_ff[s]    <= new_id_ff;
            slot_arr_ff[s]   <= new_arr_ff;
            slot_burst_ff[s] <= new_burst_ff;
            slot_rem_ff[s]   <= new_burst_ff;
            slot_prio_ff[s]  <= '0;
            slot_last_ff[s]  <= '0;
         end else if (cmd.age) begin
            slot_prio_ff[s] <= prio_age[s];
         end
      end

      if (cmd.admit) begin
         p_status_ff <= free_found ? aps_pkg::ST_ADMITTED : aps_pkg::ST_FULL;
         p_id_ff     <= '0;
         p_run_ff    <= '0;
         p_fin_ff    <= 1'b0;
         p_ta_ff     <= '0;
         p_wait_ff   <= '0;
      end

      if (cmd.run) begin
         if (best_valid_ff) begin
            slot_rem_ff[best_idx_ff]  <= rem_next;
            slot_last_ff[best_idx_ff] <= ct_run;
            run_ff                    <= run_amt;
            fin_ff                    <= (rem_next == '0);
         end else begin
            p_status_ff <= aps_pkg::ST_IDLE;
            p_id_ff     <= '0;
            p_run_ff    <= '0;
            p_fin_ff    <= 1'b0;
            p_ta_ff     <= '0;
            p_wait_ff   <= '0;
         end
      end

      if (cmd.age) ta_ff <= ct_ff - CW'(best_arr_ff);

      if (cmd.finish) begin
         p_status_ff <= aps_pkg::ST_RAN;
         p_id_ff     <= slot_id_ff[best_idx_ff];
         p_run_ff    <= run_ff;
         p_fin_ff    <= fin_ff;
         p_ta_ff     <= fin_ff ? ta_ff : '0;
         p_wait_ff   <= fin_ff ? (ta_ff - CW'(slot_burst_ff[best_idx_ff])) : '0;
      end

      if (cmd.load_rsp) begin
         rsp_status     <= p_status_ff;
         rsp_ran_id     <= p_id_ff;
         rsp_run_amount <= p_run_ff;
         rsp_finished   <= p_fin_ff;
         rsp_turnaround <= p_ta_ff;
         rsp_waiting    <= p_wait_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== test/aging_priority_scheduler_tb.sv =====
// Self-checking testbench for aging_priority_scheduler: a scoreboard class keeps its own
// copy of the process table and predicts every result, while plain tasks drive the ports.
// Depends on aps_pkg and the scheduler RTL only.
module aging_priority_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = aps_pkg::SLOTS;
   localparam int ID_W       = aps_pkg::ID_W;
   localparam int TIME_W     = aps_pkg::TIME_W;
   localparam int CT_W       = aps_pkg::CT_W;
   localparam int PRIO_W     = aps_pkg::PRIO_W;
   localparam int Q_W        = aps_pkg::Q_W;
   localparam int GAIN_W     = aps_pkg::GAIN_W;
   localparam int STATUS_W   = aps_pkg::STATUS_W;
   localparam int CSR_IDX_W  = aps_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = aps_pkg::CSR_DATA_W;

   // index 3 is not mapped; writes to it must leave the registers alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int STEP_CYCLES = SLOTS + 4;  // slowest request: scan, run, age, assemble, output load
   localparam int RAND_ITEMS  = 1450;
   localparam int PHASES      = 8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     ran_id;
      logic [Q_W-1:0]      run_amount;
      logic                finished;
      logic [CT_W-1:0]     turnaround;
      logic [CT_W-1:0]     waiting;
   } sched_result_type;

   // Process table mirror plus the queue of results still owed by the block.
   class sched_scoreboard_type;
      bit                used      [SLOTS];
      bit                done      [SLOTS];
      logic [ID_W-1:0]   pid       [SLOTS];
      logic [TIME_W-1:0] arrival   [SLOTS];
      logic [TIME_W-1:0] burst     [SLOTS];
      logic [TIME_W-1:0] remaining [SLOTS];
      logic [PRIO_W-1:0] prio      [SLOTS];
      logic [CT_W-1:0]   last_run  [SLOTS];
      logic [CT_W-1:0]   now;
      logic [Q_W-1:0]    quantum;
      logic [GAIN_W-1:0] run_gain;
      logic [GAIN_W-1:0] wait_gain;
      sched_result_type  outcomes_due [$];
      int errors, n_admit, n_full, n_ran, n_done, n_idle;

      function new();
         now       = '0;
         quantum   = aps_pkg::QUANTUM_RST;
         run_gain  = aps_pkg::RUN_GAIN_RST;
         wait_gain = aps_pkg::WAIT_GAIN_RST;
      endfunction

      function int pending();
         return outcomes_due.size();
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            aps_pkg::CSR_QUANTUM:   quantum   = data[Q_W-1:0];
            aps_pkg::CSR_RUN_GAIN:  run_gain  = data[GAIN_W-1:0];
            aps_pkg::CSR_WAIT_GAIN: wait_gain = data[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      // priority add that sticks at the top of the range
      function logic [PRIO_W-1:0] bump(logic [PRIO_W-1:0] p, logic [GAIN_W-1:0] g);
         logic [PRIO_W:0] s;
         s = {1'b0, p} + (PRIO_W+1)'(g);
         return s[PRIO_W] ? aps_pkg::PRIO_MAX : s[PRIO_W-1:0];
      endfunction

      function sched_result_type schedule(logic kind, logic [ID_W-1:0] id,
                                          logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bst);
         sched_result_type  r;
         int                sel;
         int                s;
         bit                any;
         logic [CT_W-1:0]   next;
         logic [TIME_W-1:0] run;
         r   = '0;
         sel = -1;
         if (kind == aps_pkg::KIND_ADMIT) begin
            // lowest slot that is empty or holds a finished process
            for (s = 0; s < SLOTS; s++)
               if (sel < 0 && (!used[s] || done[s])) sel = s;
            if (sel < 0) begin
               r.status = aps_pkg::ST_FULL;
               return r;
            end
            used[sel]      = 1'b1;
            done[sel]      = 1'b0;
            pid[sel]       = id;
            arrival[sel]   = arr;
            burst[sel]     = bst;
            remaining[sel] = bst;
            prio[sel]      = '0;
            last_run[sel]  = '0;
            r.status = aps_pkg::ST_ADMITTED;
            return r;
         end
         // highest priority, then least recently run, then lowest slot
         for (s = 0; s < SLOTS; s++) begin
            if (used[s] && !done[s] && CT_W'(arrival[s]) <= now) begin
               if (sel < 0 || prio[s] > prio[sel] ||
                   (prio[s] == prio[sel] && last_run[s] < last_run[sel]))
                  sel = s;
            end
         end
         if (sel < 0) begin
            // nothing ready: jump ahead to the earliest pending arrival, if any
            any  = 1'b0;
            next = '0;
            for (s = 0; s < SLOTS; s++) begin
               if (used[s] && !done[s] && (!any || CT_W'(arrival[s]) < next)) begin
                  next = CT_W'(arrival[s]);
                  any  = 1'b1;
               end
            end
            if (any && next > now) now = next;
            r.status = aps_pkg::ST_IDLE;
            return r;
         end
         run = (remaining[sel] < TIME_W'(quantum)) ? remaining[sel] : TIME_W'(quantum);
         remaining[sel] = remaining[sel] - run;
         now            = now + CT_W'(run);
         last_run[sel]  = now;
         for (s = 0; s < SLOTS; s++) begin
            if (s == sel)
               prio[s] = bump(prio[s], run_gain);
            else if (used[s] && !done[s] && CT_W'(arrival[s]) < now)
               prio[s] = bump(prio[s], wait_gain);
         end
         r.status     = aps_pkg::ST_RAN;
         r.ran_id     = pid[sel];
         r.run_amount = run[Q_W-1:0];
         if (remaining[sel] == '0) begin
            done[sel]    = 1'b1;
            r.finished   = 1'b1;
            r.turnaround = now - CT_W'(arrival[sel]);
            r.waiting    = r.turnaround - CT_W'(burst[sel]);
         end
         return r;
      endfunction

      function void note_request(logic kind, logic [ID_W-1:0] id,
                                 logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bst);
         sched_result_type r;
         r = schedule(kind, id, arr, bst);
         case (r.status)
            aps_pkg::ST_ADMITTED: n_admit++;
            aps_pkg::ST_FULL:     n_full++;
            aps_pkg::ST_RAN:      n_ran++;
            default:              n_idle++;
         endcase
         if (r.finished) n_done++;
         outcomes_due.push_back(r);
      endfunction

      task report(string msg);
         $display("aging_priority_scheduler_tb: mismatch: %s", msg);
         errors++;
      endtask

      task compare_field(string name, logic [CT_W-1:0] got, logic [CT_W-1:0] want);
         if (got !== want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      endtask

      task check_result(sched_result_type got);
         sched_result_type want;
         if (outcomes_due.size() == 0) begin
            report($sformatf("result with nothing outstanding, status %0d", got.status));
            return;
         end
         want = outcomes_due.pop_front();
         compare_field("status", CT_W'(got.status), CT_W'(want.status));
         compare_field("ran_id", CT_W'(got.ran_id), CT_W'(want.ran_id));
         compare_field("run_amount", CT_W'(got.run_amount), CT_W'(want.run_amount));
         compare_field("finished", CT_W'(got.finished), CT_W'(want.finished));
         compare_field("turnaround", got.turnaround, want.turnaround);
         compare_field("waiting", got.waiting, want.waiting);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [ID_W-1:0]       req_process_id;
   logic [TIME_W-1:0]     req_arrival_time;
   logic [TIME_W-1:0]     req_burst;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ID_W-1:0]       rsp_ran_id;
   logic [Q_W-1:0]        rsp_run_amount;
   logic                  rsp_finished;
   logic [CT_W-1:0]       rsp_turnaround;
   logic [CT_W-1:0]       rsp_waiting;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sched_scoreboard_type sb;
   int send_idle_pct;   // chance per cycle that the sender holds off
   int stall_pct;       // chance per cycle that the receiver stalls
   int sent;

   aging_priority_scheduler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_process_id   (req_process_id),
      .req_arrival_time (req_arrival_time),
      .req_burst        (req_burst),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_ran_id       (rsp_ran_id),
      .rsp_run_amount   (rsp_run_amount),
      .rsp_finished     (rsp_finished),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Monitor: everything sampled at the edge sees pre-edge values since all
   // drivers use nonblocking updates. Results are checked before the new
   // request is noted so a stray result can never borrow a fresh expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(sched_result_type'({rsp_status, rsp_ran_id, rsp_run_amount,
                                                rsp_finished, rsp_turnaround, rsp_waiting}));
         if (req_valid && !req_stall)
            sb.note_request(req_kind, req_process_id, req_arrival_time, req_burst);
         if (csr_wr_en)
            sb.set_register(csr_index, csr_wdata);
      end
   end

   // Offer one request, with a random hold-off first, and return at the edge that takes it.
   task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bst);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_process_id   <= id;
      req_arrival_time <= arr;
      req_burst        <= bst;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // step requests carry junk in the admit fields; the block must ignore it
   task automatic send_step();
      send_request(aps_pkg::KIND_STEP, ID_W'($urandom()), TIME_W'($urandom()),
                   TIME_W'($urandom()));
   endtask

   task automatic send_admit(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] arr,
                             input logic [TIME_W-1:0] bst);
      send_request(aps_pkg::KIND_ADMIT, id, arr, bst);
   endtask

   // Random admit: arrivals mostly just ahead of the scheduler clock so that
   // processes become ready soon, bursts mostly a few quanta so they finish.
   task automatic send_random_admit();
      logic [CT_W-1:0]   soon;
      logic [TIME_W-1:0] arr;
      logic [TIME_W-1:0] bst;
      int                qcap;
      int                r;
      soon = sb.now + $urandom_range(40);
      if ($urandom_range(9) == 0 || soon > 32'h0000_FFFF) arr = TIME_W'($urandom());
      else arr = soon[TIME_W-1:0];
      qcap = (sb.quantum == '0) ? 1 : int'(sb.quantum);
      r = $urandom_range(99);
      if (r < 3) bst = '0;                           // finishes without running
      else if (r < 5) bst = TIME_W'($urandom());     // long job that hogs a slot
      else bst = TIME_W'($urandom_range(1, 3 * qcap));
      send_admit(ID_W'($urandom()), arr, bst);
   endtask

   // Stop offering and wait until every owed result has been taken.
   // The first edge lets the monitor note the request just accepted.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all registers (plus the unmapped index) on back-to-back edges.
   // Gain writes carry random upper bits that must be dropped.
   task automatic configure(input logic [Q_W-1:0] q, input logic [GAIN_W-1:0] rg,
                            input logic [GAIN_W-1:0] wg);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom());
      @(posedge clock);
      csr_index <= aps_pkg::CSR_QUANTUM;
      csr_wdata <= q;
      @(posedge clock);
      csr_index <= aps_pkg::CSR_RUN_GAIN;
      csr_wdata <= {(CSR_DATA_W-GAIN_W)'($urandom()), rg};
      @(posedge clock);
      csr_index <= aps_pkg::CSR_WAIT_GAIN;
      csr_wdata <= {(CSR_DATA_W-GAIN_W)'($urandom()), wg};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int p;
      int stop_at;
      sb = new();
      sent          = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= aps_pkg::KIND_ADMIT;
      req_process_id   <= '0;
      req_arrival_time <= '0;
      req_burst        <= '0;
      rsp_stall        <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= aps_pkg::CSR_QUANTUM;
      csr_wdata        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, at reset register values (quantum 1, gains 1 and 2) ---
      send_step();                                  // empty table: idle, clock holds
      send_admit(8'hFF, 16'h0000, 16'h0000);        // zero burst
      send_admit(8'h00, 16'hFFFF, 16'hFFFF);        // latest arrival, longest burst
      send_admit(8'h5A, 16'h0003, 16'h0002);
      send_step();                                  // zero burst completes, runs 0
      send_step();                                  // nothing ready: clock jumps to 3
      send_step();
      send_admit(8'h81, 16'h0000, 16'h0001);        // reuses the freed slot
      send_step();
      send_step();
      drain();
      configure(8'd0, 4'd15, 4'd15);
      send_step();                                  // jump to the far arrival
      send_step();                                  // zero quantum: runs 0 units
      send_step();
      drain();
      configure(8'd255, 4'd0, 4'd15);
      send_admit(8'h3C, 16'h0000, 16'h00FF);
      repeat (4) send_step();

      // --- random part: register setting and idle pattern change per phase ---
      for (p = 0; p < PHASES; p++) begin
         drain();                                   // also the full pause of the sender
         case (p)
            0: configure(aps_pkg::QUANTUM_RST, aps_pkg::RUN_GAIN_RST,
                         aps_pkg::WAIT_GAIN_RST);
            1: configure(8'd255, 4'd15, 4'd15);
            2: configure(8'd1, 4'd0, 4'd15);
            3: configure(8'd255, 4'd15, 4'd0);
            default: configure(Q_W'($urandom_range(1, 255)), GAIN_W'($urandom()),
                               GAIN_W'($urandom()));
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
         endcase
         stop_at = sent + RAND_ITEMS / PHASES;
         while (sent < stop_at) begin
            // now and then a run of admits that overflows the table
            if ($urandom_range(99) < 3)
               repeat (SLOTS + 2) send_random_admit();
            else if ($urandom_range(99) < 45)
               send_random_admit();
            else
               send_step();
         end
      end

      drain();
      repeat (STEP_CYCLES) @(posedge clock);
      $display("aging_priority_scheduler_tb: %0d requests: %0d admitted, %0d refused (table full)",
               sent, sb.n_admit, sb.n_full);
      $display("aging_priority_scheduler_tb: %0d runs with %0d completions, %0d idle steps, %0d phases",
               sb.n_ran, sb.n_done, sb.n_idle, PHASES);
      if (sb.errors == 0)
         $display("aging_priority_scheduler_tb: done, clean");
      else
         $display("aging_priority_scheduler_tb: done, errors");
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("aging_priority_scheduler_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aps_pkg.sv
rtl/aps_ctrl.sv
rtl/aps_dp.sv
rtl/aging_priority_scheduler.sv
test/aging_priority_scheduler_tb.sv
